// ===== rtl/fifo_queue_reverse_first_k_core_assert.svh =====
// Assertion macros for the queue core checks.
// Used by fifo_queue_reverse_first_k_core.sv; expects clk and rst_n in scope.
`ifndef FIFO_QUEUE_REVERSE_FIRST_K_CORE_ASSERT_SVH
`define FIFO_QUEUE_REVERSE_FIRST_K_CORE_ASSERT_SVH

// Check that post holds in the same cycle as pre
`define QRK_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check that post holds in the cycle after pre
`define QRK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/qrk_pkg.sv =====
// Shared types and codes of the queue core: request kinds, status codes
// and sequencer states. No dependencies.
package qrk_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_REV  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_KBIG  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RDA,
    S_RDB,
    S_WRA,
    S_WRB
  } state_t;

  localparam int DATA_PORT_W = 32;
  localparam int K_PORT_W    = 8;

endpackage

// ===== rtl/qrk_slot_unit.sv =====
// Shared slot address unit: (base + offset) modulo DEPTH.
// Standalone; offset never exceeds DEPTH, so one compare and subtract wraps it.
module qrk_slot_unit #(
  parameter int DEPTH = 128
) (
  input  logic [$clog2(DEPTH)-1:0]   base,
  input  logic [$clog2(DEPTH+1)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0]   slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;

  logic [SW-1:0] sum;

  // Add, then wrap once past the end of the buffer
  always_comb begin
    sum = SW'(base) + SW'(offset);
    if (sum >= SW'(DEPTH)) begin
      slot = AW'(sum - SW'(DEPTH));
    end else begin
      slot = AW'(sum);
    end
  end

endmodule

// ===== rtl/qrk_store.sv =====
// Entry storage of the queue: one write port, one read port, registered read.
// Standalone; contents are undefined until written.
module qrk_store #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fifo_queue_reverse_first_k_core.sv =====
// Top level of the queue core with reverse-first-k requests.
// Depends on qrk_pkg, qrk_slot_unit, qrk_store and the assertion header.
//
// Usage:
//   Request channel: drive in_op, in_value, in_k_count and raise start; the
//   transaction is taken at the clock edge where start is high and busy low.
//   busy stays high until the single result has been issued.
//   Result channel: out_valid pulses for one cycle with out_data, out_status
//   and out_fill_count; the receiver cannot stall it and must take it then.
// Steps per request (accept edge to next possible accept edge):
//   enqueue           execute
//   dequeue, peek     execute, then read (one registered memory read)
//   reverse first k   execute alone when nothing moves, else execute and then floor(k/2) pair swaps
//   A reverse swaps each pair in the order read a, read b, write a,
//   write b, all through the single read and single write port of the
//   entry store and the one shared slot address adder.
// Reset (rst_n low, synchronous): the queue becomes empty, head at slot 0,
//   no result pending. The entry store is not cleared; only written slots
//   are ever read.
module fifo_queue_reverse_first_k_core #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_value,
  input  logic [7:0]  in_k_count,
  output logic        out_valid,
  output logic signed [31:0] out_data,
  output logic [1:0]  out_status,
  output logic [7:0]  out_fill_count
);

`include "fifo_queue_reverse_first_k_core_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > qrk_pkg::K_PORT_W) ? CW : qrk_pkg::K_PORT_W;

  qrk_pkg::state_t state_r, state_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [31:0]           value_r, value_nxt;
  logic [7:0]            k_r, k_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         lo_r, lo_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [AW-1:0]         slot_a_r, slot_a_nxt;
  logic [AW-1:0]         slot_b_r, slot_b_nxt;
  logic [DATA_WIDTH-1:0] tmp_a_r, tmp_a_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [7:0]            out_fill_r, out_fill_nxt;

  logic [CW-1:0]         slot_off;
  logic [AW-1:0]         slot;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic signed [DATA_WIDTH-1:0] rdata_s;

  logic [AW-1:0]         lo_inc;
  logic [AW-1:0]         hi_dec;

  qrk_slot_unit #(.DEPTH(DEPTH)) u_slot (
    .base   (head_r),
    .offset (slot_off),
    .slot   (slot)
  );

  qrk_store #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rdata_s = mem_rdata;
  assign lo_inc  = lo_r + AW'(1);
  assign hi_dec  = hi_r - AW'(1);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qrk_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    k_r          <= k_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    slot_a_r     <= slot_a_nxt;
    slot_b_r     <= slot_b_nxt;
    tmp_a_r      <= tmp_a_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  // Sequencer: next state, memory port and result
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    k_nxt          = k_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    slot_a_nxt     = slot_a_r;
    slot_b_nxt     = slot_b_r;
    tmp_a_nxt      = tmp_a_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    out_status_nxt = qrk_pkg::ST_OK;
    out_fill_nxt   = 8'(count_r);
    slot_off       = '0;
    mem_we         = 1'b0;
    mem_waddr      = slot;
    mem_wdata      = mem_rdata;
    mem_raddr      = slot;

    unique case (state_r)
      qrk_pkg::S_IDLE: begin
        // Latch the request transaction
        if (start) begin
          op_nxt    = in_op;
          value_nxt = in_value;
          k_nxt     = in_k_count;
          state_nxt = qrk_pkg::S_EXEC;
        end
      end

      qrk_pkg::S_EXEC: begin
        case (op_r) inside
          qrk_pkg::OP_ENQ: begin
            // Append at head + count unless full
            slot_off      = count_r;
            out_valid_nxt = 1'b1;
            state_nxt     = qrk_pkg::S_IDLE;
            if (count_r == CW'(DEPTH)) begin
              out_status_nxt = qrk_pkg::ST_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = slot;
              mem_wdata    = DATA_WIDTH'(value_r);
              count_nxt    = count_r + CW'(1);
              out_fill_nxt = 8'(count_r + CW'(1));
            end
          end
          qrk_pkg::OP_DEQ, qrk_pkg::OP_PEEK: begin
            // Read the head entry unless empty
            slot_off  = '0;
            mem_raddr = slot;
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = qrk_pkg::ST_EMPTY;
              state_nxt      = qrk_pkg::S_IDLE;
            end else begin
              state_nxt = qrk_pkg::S_READ;
            end
          end
          default: begin
            // Reverse: trivial k, oversized k, or start the swap loop
            if (k_r <= 8'd1) begin
              out_valid_nxt = 1'b1;
              state_nxt     = qrk_pkg::S_IDLE;
            end else if (KW'(k_r) > KW'(count_r)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = qrk_pkg::ST_KBIG;
              state_nxt      = qrk_pkg::S_IDLE;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = AW'(k_r - 8'd1);
              state_nxt = qrk_pkg::S_RDA;
            end
          end
        endcase
      end

      qrk_pkg::S_READ: begin
        // Return the head word; a dequeue also advances the head
        slot_off      = CW'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = qrk_pkg::DATA_PORT_W'(rdata_s);
        state_nxt     = qrk_pkg::S_IDLE;
        if (op_r == qrk_pkg::OP_DEQ) begin
          head_nxt     = slot;
          count_nxt    = count_r - CW'(1);
          out_fill_nxt = 8'(count_r - CW'(1));
        end
      end

      qrk_pkg::S_RDA: begin
        // Read the low entry of the pair
        slot_off   = CW'(lo_r);
        mem_raddr  = slot;
        slot_a_nxt = slot;
        state_nxt  = qrk_pkg::S_RDB;
      end

      qrk_pkg::S_RDB: begin
        // Hold the low word, read the high entry
        tmp_a_nxt  = mem_rdata;
        slot_off   = CW'(hi_r);
        mem_raddr  = slot;
        slot_b_nxt = slot;
        state_nxt  = qrk_pkg::S_WRA;
      end

      qrk_pkg::S_WRA: begin
        // Store the high word at the low slot
        mem_we    = 1'b1;
        mem_waddr = slot_a_r;
        mem_wdata = mem_rdata;
        state_nxt = qrk_pkg::S_WRB;
      end

      qrk_pkg::S_WRB: begin
        // Store the low word at the high slot, advance both ends
        mem_we    = 1'b1;
        mem_waddr = slot_b_r;
        mem_wdata = tmp_a_r;
        lo_nxt    = lo_inc;
        hi_nxt    = hi_dec;
        if (lo_inc < hi_dec) begin
          state_nxt = qrk_pkg::S_RDA;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = qrk_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = qrk_pkg::S_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != qrk_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

  // Checks
  `QRK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `QRK_ASSERT_SAME(a_result_idle, out_valid, !busy, "result issued while still busy")
  `QRK_ASSERT_SAME(a_full_count, out_valid && (out_status == qrk_pkg::ST_FULL), count_r == CW'(DEPTH), "full status with room left")
  `QRK_ASSERT_SAME(a_swap_order, state_r == qrk_pkg::S_RDA, lo_r < hi_r, "swap pair out of order")

endmodule
